FILE: design/b64s_pkg.sv
// ----------------------------------------------------------------------------
// b64s_pkg
// Shared types, constants and the sextet-to-character lookup for the
// base64 encoder with running character sum.
// ----------------------------------------------------------------------------
package b64s_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // one slot of a command: pad flag over a 6-bit sextet
   typedef struct packed {
      logic       pad;
      logic [5:0] sextet;
   } slot_type;

   // everything the emitter needs for one input word
   typedef struct packed {
      slot_type [3:0] slots;
      logic [1:0]     last_idx;
      logic           frame_end;
   } cmd_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage

FILE: design/b64s_front.sv
// ----------------------------------------------------------------------------
// b64s_front
// Accepts raw bytes, tracks the group position and leftover bits, and turns
// each byte into a command of one to four character slots.
// ----------------------------------------------------------------------------
module b64s_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tlast,   // final_byte
   output logic              push,
   output b64s_pkg::cmd_type push_cmd,
   input  logic              queue_full
);
   import b64s_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   cmd_type    cmd;

   always_comb begin
      cmd       = '0;
      phase_in  = phase_ff;
      left_in   = left_ff;
      case (phase_ff)
         2'd1: begin
            cmd.slots[0].sextet = {left_ff[1:0], req_tdata[7:4]};
            cmd.last_idx        = 2'd0;
            left_in             = req_tdata[3:0];
            phase_in            = 2'd2;
         end
         2'd2, 2'd3: begin
            cmd.slots[0].sextet = {left_ff[3:0], req_tdata[7:6]};
            cmd.slots[1].sextet = req_tdata[5:0];
            cmd.last_idx        = 2'd1;
            left_in             = 4'd0;
            phase_in            = 2'd0;
         end
         default: begin
            cmd.slots[0].sextet = req_tdata[7:2];
            cmd.last_idx        = 2'd0;
            left_in             = {2'b00, req_tdata[1:0]};
            phase_in            = 2'd1;
         end
      endcase

      if (req_tlast) begin
         cmd.frame_end = 1'b1;
         // flush the pending bits and pad out the group
         case (phase_in)
            2'd1: begin
               cmd.slots[1].sextet = {req_tdata[1:0], 4'd0};
               cmd.slots[2].pad    = 1'b1;
               cmd.slots[3].pad    = 1'b1;
               cmd.last_idx        = 2'd3;
            end
            2'd2: begin
               cmd.slots[1].sextet = {req_tdata[3:0], 2'd0};
               cmd.slots[2].pad    = 1'b1;
               cmd.last_idx        = 2'd2;
            end
            default: begin
            end
         endcase
         phase_in = 2'd0;
         left_in  = 4'd0;
      end
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;
   assign push_cmd   = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         left_ff  <= 4'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

FILE: design/b64s_queue.sv
// ----------------------------------------------------------------------------
// b64s_queue
// Small command queue between the byte front end and the character emitter.
// ----------------------------------------------------------------------------
module b64s_queue #(
   parameter int Depth = b64s_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64s_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output b64s_pkg::cmd_type head_cmd
);
   import b64s_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   cmd_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: design/b64s_back.sv
// ----------------------------------------------------------------------------
// b64s_back
// Walks the head command's slots, one character per cycle unless stalled,
// keeps the running character sum and drives the registered output word.
// ----------------------------------------------------------------------------
module b64s_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  b64s_pkg::cmd_type head_cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // [7:0] out_char, [23:8] run_sum
   output logic              rsp_tlast    // frame_end
);
   import b64s_pkg::*;

   logic [1:0]  idx_ff;
   logic [15:0] sum_ff;
   logic        valid_ff;
   logic [23:0] data_ff;
   logic        last_ff;

   slot_type    slot;
   logic [7:0]  ch;
   logic [15:0] sum_next;
   logic        fire;
   logic        last_slot;
   logic        end_char;

   always_comb begin
      slot      = head_cmd.slots[idx_ff];
      ch        = slot.pad ? PAD_CHAR : b64_char(slot.sextet);
      sum_next  = sum_ff + {8'd0, ch};
      fire      = head_valid && (!valid_ff || rsp_tready);
      last_slot = (idx_ff == head_cmd.last_idx);
      end_char  = last_slot && head_cmd.frame_end;
   end

   assign pop        = fire && last_slot;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         sum_ff   <= 16'd0;
         valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            idx_ff   <= last_slot ? 2'd0 : idx_ff + 2'd1;
            // sum restarts after the last character of a frame
            sum_ff   <= end_char ? 16'd0 : sum_next;
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= {sum_next, ch};
         last_ff <= end_char;
      end
   end

endmodule

FILE: design/base64_encoder_with_sum16.sv
// A byte's first character passes the command queue, then the registered output word.
// Throughput: one output character per cycle while the output is not stalled; a byte gives
// one or two characters, or two to four when it ends a frame (single-character emitter).
// A command queue of QueueDepth entries lets bytes be taken while characters drain.
// Reset (synchronous, active high) clears group position, leftover bits, sum and queue.
// ----------------------------------------------------------------------------
// base64_encoder_with_sum16
// Base64 encoder (standard alphabet) with '=' padding on the last byte and a
// 16-bit wrapping sum of the emitted characters per frame.
// ----------------------------------------------------------------------------
module base64_encoder_with_sum16 #(
   parameter int QueueDepth = b64s_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_char, [23:8] run_sum
   output logic        rsp_tlast    // frame_end
);
   import b64s_pkg::*;

   logic    push;
   logic    pop;
   logic    queue_full;
   logic    head_valid;
   cmd_type push_cmd;
   cmd_type head_cmd;

   b64s_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   b64s_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   b64s_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
